### design/cpk_pkg.sv
`timescale 1ns / 1ps

package cpk_pkg;

   // field widths
   localparam int ID_W       = 64;
   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int VER_W      = 8;
   localparam int LIMIT_W    = 7;
   localparam int RANK_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // defaults
   localparam int                 CAPACITY_DEF    = 64;
   localparam logic [VER_W-1:0]   MIN_VERSION_RST = 8'd8;
   localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST  = 7'd50;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ID_LOW  = 2'd0,
      CSR_OWN_ID_HIGH = 2'd1,
      CSR_MIN_VERSION = 2'd2,
      CSR_KEEP_LIMIT  = 2'd3
   } csr_index_type;

   // input item
   typedef struct packed {
      logic              record_valid;
      logic              end_of_file;
      logic [ID_W-1:0]   peer_id_low;
      logic [ID_W-1:0]   peer_id_high;
      logic [IP_W-1:0]   peer_ip;
      logic [PORT_W-1:0] peer_udp;
      logic [PORT_W-1:0] peer_tcp;
      logic [VER_W-1:0]  peer_version;
   } req_type;

   // result item
   typedef struct packed {
      logic              entry_valid;
      logic              last;
      logic [RANK_W-1:0] rank;
      logic [ID_W-1:0]   out_id_low;
      logic [ID_W-1:0]   out_id_high;
      logic [IP_W-1:0]   out_ip;
      logic [PORT_W-1:0] out_udp_port;
      logic [PORT_W-1:0] out_tcp_port;
      logic [VER_W-1:0]  out_version;
   } rsp_type;

   // one stored peer
   typedef struct packed {
      logic [ID_W-1:0]   id_low;
      logic [ID_W-1:0]   id_high;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] udp;
      logic [PORT_W-1:0] tcp;
      logic [VER_W-1:0]  version;
   } slot_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan_rd;
      logic shift_start;
      logic shift_rd;
      logic insert;
      logic out_start;
      logic out_rd;
      logic out_load;
      logic out_empty;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic take;
      logic eof;
      logic scan_more;
      logic admit;
      logic shift_more;
      logic count_zero;
      logic out_last;
   } stat_type;

endpackage

### design/closest_peer_keeper_core.sv
// per item: idle and start, then for a record at or above the version floor a scan of the
// held peers and a decide step; an admitted record then shifts the entries from its insert
// position up by one slot, dropping the last at capacity, and is inserted
// read-out: a start, then a read and a load per result; one slot memory port sets the pace
// one item in work at a time; a result waiting in the output register does not stall input
// reset: configuration back to defaults and the list empty; slot memory is not cleared
`timescale 1ns / 1ps

module closest_peer_keeper_core #(
   parameter int CAPACITY = cpk_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [cpk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cpk_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  cpk_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cpk_pkg::rsp_type               rsp_data
);
   import cpk_pkg::*;

   cmd_type  cmd;
   stat_type st;

   // sequencer
   cpk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .st        (st)
   );

   // slot memory, compare and output register
   cpk_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .st          (st)
   );

endmodule

### design/cpk_ctrl.sv
`timescale 1ns / 1ps

module cpk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpk_pkg::cmd_type  cmd,
   input  cpk_pkg::stat_type st
);
   import cpk_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_INSERT,
      ST_OUT_START,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_OUT_EMPTY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // output register can take a new result
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (st.take) begin
               state_in = ST_SCAN;
            end else if (st.eof) begin
               state_in = ST_OUT_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (st.scan_more) begin
               cmd.scan_rd = 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (st.admit) begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end else if (st.eof) begin
               state_in = ST_OUT_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (st.shift_more) begin
               cmd.shift_rd = 1'b1;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = st.eof ? ST_OUT_START : ST_IDLE;
         end
         ST_OUT_START: begin
            cmd.out_start = 1'b1;
            state_in      = st.count_zero ? ST_OUT_EMPTY : ST_OUT_RD;
         end
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = st.out_last ? ST_IDLE : ST_OUT_RD;
            end
         end
         ST_OUT_EMPTY: begin
            if (rsp_free) begin
               cmd.out_empty = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/cpk_datapath.sv
`timescale 1ns / 1ps

module cpk_datapath #(
   parameter int CAPACITY = cpk_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [cpk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpk_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  cpk_pkg::req_type                   req_data,
   output cpk_pkg::rsp_type                   rsp_data,
   input  cpk_pkg::cmd_type                   cmd,
   output cpk_pkg::stat_type                  st
);
   import cpk_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // configuration
   logic [ID_W-1:0]    own_low_ff, own_low_in;
   logic [ID_W-1:0]    own_high_ff, own_high_in;
   logic [VER_W-1:0]   min_ver_ff, min_ver_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   // held record
   slot_type           rec_slot_ff;
   logic               rec_vld_ff;
   logic               rec_eof_ff;
   logic [2*ID_W-1:0]  dist_ff;

   // list control
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               found_ff, found_in;
   logic               last_far_ff, last_far_in;
   logic               cmp_vld_ff;
   logic [CNT_W-1:0]   cmp_idx_ff;
   logic               sh_vld_ff;
   logic [IDX_W-1:0]   sh_addr_ff;

   // slot memory
   slot_type           slot_mem_ff [CAPACITY];
   slot_type           rd_data_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   slot_type           wr_data;

   rsp_type            rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]   idx_dec;
   logic [CNT_W-1:0]   cnt_m1;
   logic [CNT_W-1:0]   top;
   logic [LIM_W-1:0]   lim_ext;
   logic [LIM_W-1:0]   lim_wide;
   logic [CNT_W-1:0]   lim;
   logic [CNT_W:0]     cnt_inc;
   logic [CNT_W-1:0]   cnt_new;
   logic               far;

   // effective limit, clamped to one and to capacity
   always_comb begin
      lim_ext = LIM_W'(limit_ff);
      if (lim_ext == '0) begin
         lim_wide = LIM_W'(1);
      end else if (lim_ext > LIM_W'(CAPACITY)) begin
         lim_wide = LIM_W'(CAPACITY);
      end else begin
         lim_wide = lim_ext;
      end
      lim = CNT_W'(lim_wide);
   end

   assign idx_dec = idx_ff - CNT_W'(1);
   assign cnt_m1  = count_ff - CNT_W'(1);
   assign top     = (count_ff > CNT_W'(CAPACITY - 1)) ? CNT_W'(CAPACITY - 1) : count_ff;
   assign cnt_inc = {1'b0, count_ff} + (CNT_W + 1)'(1);
   assign cnt_new = (cnt_inc > {1'b0, lim}) ? lim : cnt_inc[CNT_W-1:0];

   // stored peer strictly farther than the new one
   assign far = ({rd_data_ff.id_high, rd_data_ff.id_low} ^ {own_high_ff, own_low_ff}) > dist_ff;

   // status to controller
   always_comb begin
      st            = '0;
      st.take       = rec_vld_ff && (rec_slot_ff.version >= min_ver_ff);
      st.eof        = rec_eof_ff;
      st.scan_more  = idx_ff < count_ff;
      st.admit      = (count_ff < lim) || last_far_ff;
      st.shift_more = idx_ff > pos_ff;
      st.count_zero = (count_ff == '0);
      st.out_last   = (idx_ff == cnt_m1);
   end

   // configuration writes
   always_comb begin
      own_low_in  = own_low_ff;
      own_high_in = own_high_ff;
      min_ver_in  = min_ver_ff;
      limit_in    = limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OWN_ID_LOW:  own_low_in  = csr_wr_data;
            CSR_OWN_ID_HIGH: own_high_in = csr_wr_data;
            CSR_MIN_VERSION: min_ver_in  = csr_wr_data[VER_W-1:0];
            CSR_KEEP_LIMIT:  limit_in    = csr_wr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // index, scan result and count
   always_comb begin
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      found_in    = found_ff;
      last_far_in = last_far_ff;
      count_in    = count_ff;

      if (cmd.load || cmd.out_start) begin
         idx_in = '0;
      end else if (cmd.scan_rd || cmd.out_load) begin
         idx_in = idx_ff + CNT_W'(1);
      end else if (cmd.shift_start) begin
         idx_in = top;
      end else if (cmd.shift_rd) begin
         idx_in = idx_dec;
      end

      if (cmd.load) begin
         pos_in      = count_ff;
         found_in    = 1'b0;
         last_far_in = 1'b0;
      end else if (cmp_vld_ff) begin
         // first strictly farther entry, and the verdict on the last entry
         if (far && !found_ff) begin
            found_in = 1'b1;
            pos_in   = cmp_idx_ff;
         end
         if (cmp_idx_ff == cnt_m1) begin
            last_far_in = far;
         end
      end

      if (cmd.insert) begin
         count_in = cnt_new;
      end else if (cmd.out_load && st.out_last) begin
         count_in = '0;
      end
   end

   // memory ports
   always_comb begin
      rd_en   = cmd.scan_rd || cmd.shift_rd || cmd.out_rd;
      rd_addr = cmd.shift_rd ? idx_dec[IDX_W-1:0] : idx_ff[IDX_W-1:0];
      wr_en   = sh_vld_ff || cmd.insert;
      wr_addr = sh_vld_ff ? sh_addr_ff : pos_ff[IDX_W-1:0];
      wr_data = sh_vld_ff ? rd_data_ff : rec_slot_ff;
   end

   // output register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_data_in.entry_valid  = 1'b1;
         rsp_data_in.last         = st.out_last;
         rsp_data_in.rank         = RANK_W'(idx_ff);
         rsp_data_in.out_id_low   = rd_data_ff.id_low;
         rsp_data_in.out_id_high  = rd_data_ff.id_high;
         rsp_data_in.out_ip       = rd_data_ff.ip;
         rsp_data_in.out_udp_port = rd_data_ff.udp;
         rsp_data_in.out_tcp_port = rd_data_ff.tcp;
         rsp_data_in.out_version  = rd_data_ff.version;
      end else if (cmd.out_empty) begin
         rsp_data_in      = '0;
         rsp_data_in.last = 1'b1;
      end
   end

   assign rsp_data = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_low_ff  <= '0;
         own_high_ff <= '0;
         min_ver_ff  <= MIN_VERSION_RST;
         limit_ff    <= KEEP_LIMIT_RST;
         count_ff    <= '0;
         idx_ff      <= '0;
         pos_ff      <= '0;
         found_ff    <= 1'b0;
         last_far_ff <= 1'b0;
         cmp_vld_ff  <= 1'b0;
         sh_vld_ff   <= 1'b0;
      end else begin
         own_low_ff  <= own_low_in;
         own_high_ff <= own_high_in;
         min_ver_ff  <= min_ver_in;
         limit_ff    <= limit_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         pos_ff      <= pos_in;
         found_ff    <= found_in;
         last_far_ff <= last_far_in;
         cmp_vld_ff  <= cmd.scan_rd;
         sh_vld_ff   <= cmd.shift_rd;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rec_vld_ff          <= req_data.record_valid;
         rec_eof_ff          <= req_data.end_of_file;
         rec_slot_ff.id_low  <= req_data.peer_id_low;
         rec_slot_ff.id_high <= req_data.peer_id_high;
         rec_slot_ff.ip      <= req_data.peer_ip;
         rec_slot_ff.udp     <= req_data.peer_udp;
         rec_slot_ff.tcp     <= req_data.peer_tcp;
         rec_slot_ff.version <= req_data.peer_version;
         dist_ff <= {req_data.peer_id_high, req_data.peer_id_low} ^ {own_high_ff, own_low_ff};
      end
      cmp_idx_ff  <= idx_ff;
      sh_addr_ff  <= idx_ff[IDX_W-1:0];
      rsp_data_ff <= rsp_data_in;
   end

   // slot memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   // checks
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("kept count above capacity");

   a_insert_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (pos_ff < CNT_W'(CAPACITY)))
      else $error("insert position beyond capacity");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(sh_vld_ff && cmd.insert))
      else $error("shift write and insert in the same cycle");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && st.out_last) |=> (count_ff == '0))
      else $error("list not cleared after final read-out transfer");

endmodule

### verif/tb_closest_peer_keeper_core.sv
`timescale 1ns / 1ps

module tb_closest_peer_keeper_core;
   import cpk_pkg::*;

   localparam int PEER_SLOTS   = CAPACITY_DEF;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 10000000;

   // how the result of a directed row is checked
   typedef enum logic [1:0] {
      EXP_MODEL,
      EXP_EMPTY,
      EXP_SOLE
   } check_kind_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_wr_en;
   csr_index_type csr_index;
   logic [63:0]   csr_wr_data;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;

   closest_peer_keeper_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected copy of the configuration and the sorted peer list
   logic [63:0]     own_low_r   = '0;
   logic [63:0]     own_high_r  = '0;
   logic [7:0]      min_ver_r   = MIN_VERSION_RST;
   logic [6:0]      limit_r     = KEEP_LIMIT_RST;
   slot_type        peer_slots [PEER_SLOTS];
   int unsigned     held_count  = 0;
   rsp_type         expected_peers [$];

   logic [127:0]    id_pool [8];
   check_kind_type  held_kind   = EXP_MODEL;
   int unsigned     burst_left  = 0;
   bit              failed      = 1'b0;
   int unsigned     cycle_count = 0;

   req_type         script_items [$];
   check_kind_type  script_kinds [$];

   function automatic logic [127:0] distance_of(input logic [63:0] hi, input logic [63:0] lo);
      return {hi ^ own_high_r, lo ^ own_low_r};
   endfunction

   // insert a peer before the first strictly farther entry, dropping the farthest
   function automatic void place_peer(input req_type it);
      logic [127:0] d;
      int unsigned  lim;
      int unsigned  pos;
      int unsigned  top;
      int unsigned  i;
      d   = distance_of(it.peer_id_high, it.peer_id_low);
      lim = limit_r;
      if (lim < 1) lim = 1;
      if (lim > PEER_SLOTS) lim = PEER_SLOTS;
      if (held_count >= lim) begin
         if (distance_of(peer_slots[held_count-1].id_high, peer_slots[held_count-1].id_low) <= d)
            return;
      end
      pos = held_count;
      for (i = 0; i < held_count; i++) begin
         if (distance_of(peer_slots[i].id_high, peer_slots[i].id_low) > d) begin
            pos = i;
            break;
         end
      end
      if (pos >= PEER_SLOTS) return;
      top = (held_count > PEER_SLOTS - 1) ? PEER_SLOTS - 1 : held_count;
      for (i = top; i > pos; i--) peer_slots[i] = peer_slots[i-1];
      peer_slots[pos].id_low  = it.peer_id_low;
      peer_slots[pos].id_high = it.peer_id_high;
      peer_slots[pos].ip      = it.peer_ip;
      peer_slots[pos].udp     = it.peer_udp;
      peer_slots[pos].tcp     = it.peer_tcp;
      peer_slots[pos].version = it.peer_version;
      held_count = (held_count + 1 > lim) ? lim : held_count + 1;
   endfunction

   // one accepted item: admit the record, then on end of file queue the read-out
   function automatic void advance_peer_list(input req_type it);
      rsp_type     r;
      int unsigned i;
      if (it.record_valid && it.peer_version >= min_ver_r) place_peer(it);
      if (!it.end_of_file) return;
      if (held_count == 0) begin
         r = '0;
         r.last = 1'b1;
         expected_peers.insert(expected_peers.size(), r);
         return;
      end
      for (i = 0; i < held_count; i++) begin
         r              = '0;
         r.entry_valid  = 1'b1;
         r.last         = (i + 1 == held_count);
         r.rank         = RANK_W'(i);
         r.out_id_low   = peer_slots[i].id_low;
         r.out_id_high  = peer_slots[i].id_high;
         r.out_ip       = peer_slots[i].ip;
         r.out_udp_port = peer_slots[i].udp;
         r.out_tcp_port = peer_slots[i].tcp;
         r.out_version  = peer_slots[i].version;
         expected_peers.insert(expected_peers.size(), r);
      end
      held_count = 0;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failed = 1'b1;
      end
   endfunction

   // identifiers: random, shared pool for equal distances, near own, extremes
   function automatic logic [127:0] pick_peer_id();
      logic [127:0] own;
      own = {own_high_r, own_low_r};
      case ($urandom_range(0, 5))
         0, 1:    return {$urandom, $urandom, $urandom, $urandom};
         2:       return id_pool[$urandom_range(0, 7)];
         3:       return own ^ 128'($urandom_range(0, 255));
         4:       return own ^ {$urandom, 96'h0};
         default: return ($urandom_range(0, 1) != 0) ? {128{1'b1}} : 128'h0;
      endcase
   endfunction

   function automatic req_type random_record();
      req_type      it;
      logic [127:0] id;
      id              = pick_peer_id();
      it.record_valid = 1'b1;
      it.end_of_file  = 1'b0;
      it.peer_id_high = id[127:64];
      it.peer_id_low  = id[63:0];
      it.peer_ip      = $urandom;
      it.peer_udp     = 16'($urandom);
      it.peer_tcp     = 16'($urandom);
      if ($urandom_range(0, 7) == 0) it.peer_version = 8'($urandom);
      else it.peer_version = 8'($urandom_range(min_ver_r, 255));
      return it;
   endfunction

   // transfer monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      rsp_type     want;
      rsp_type     got;
      int unsigned before_n;
      if (!reset) begin
         if (req_valid && req_ready) begin
            before_n = expected_peers.size();
            advance_peer_list(req_data);
            if (held_kind != EXP_MODEL) begin
               while (expected_peers.size() > before_n)
                  expected_peers.delete(expected_peers.size() - 1);
               want      = '0;
               want.last = 1'b1;
               if (held_kind == EXP_SOLE) begin
                  want.entry_valid  = 1'b1;
                  want.out_id_low   = req_data.peer_id_low;
                  want.out_id_high  = req_data.peer_id_high;
                  want.out_ip       = req_data.peer_ip;
                  want.out_udp_port = req_data.peer_udp;
                  want.out_tcp_port = req_data.peer_tcp;
                  want.out_version  = req_data.peer_version;
               end
               expected_peers.insert(expected_peers.size(), want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_peers.size() == 0) begin
               $error("result transfer with no entry expected");
               failed = 1'b1;
            end else begin
               want = expected_peers.pop_front();
               check_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
               check_field("last", 64'(want.last), 64'(got.last));
               check_field("rank", 64'(want.rank), 64'(got.rank));
               check_field("out_id_low", want.out_id_low, got.out_id_low);
               check_field("out_id_high", want.out_id_high, got.out_id_high);
               check_field("out_ip", 64'(want.out_ip), 64'(got.out_ip));
               check_field("out_udp_port", 64'(want.out_udp_port), 64'(got.out_udp_port));
               check_field("out_tcp_port", 64'(want.out_tcp_port), 64'(got.out_tcp_port));
               check_field("out_version", 64'(want.out_version), 64'(got.out_version));
            end
         end
      end
   end

   // receiver stalls: always ready, coin flip, one in four, or long holds
   int unsigned ready_mode = 0;
   int unsigned ready_left = 0;
   int unsigned stall_left = 0;
   int unsigned ready_tick = 0;

   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(20, 200);
      end else begin
         ready_left--;
      end
      ready_tick++;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (ready_tick % 4 == 0);
         default: begin
            if (stall_left != 0) begin
               rsp_ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 20);
            end
         end
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // sender: bursts of random length with random gaps in between
   task automatic send_item(input req_type it, input check_kind_type kind);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 12);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      held_kind  = kind;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // wait until every result has arrived, then let the last item finish
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_peers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [63:0] own_lo, input logic [63:0] own_hi,
                            input logic [7:0] min_ver, input logic [6:0] limit);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_OWN_ID_LOW;
      csr_wr_data <= own_lo;
      @(negedge clock);
      csr_index   <= CSR_OWN_ID_HIGH;
      csr_wr_data <= own_hi;
      @(negedge clock);
      csr_index   <= CSR_MIN_VERSION;
      csr_wr_data <= 64'(min_ver);
      @(negedge clock);
      csr_index   <= CSR_KEEP_LIMIT;
      csr_wr_data <= 64'(limit);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      own_low_r  = own_lo;
      own_high_r = own_hi;
      min_ver_r  = min_ver;
      limit_r    = limit;
   endtask

   // files of records with some noise, each closed by end of file unless close_last is clear for the last one
   task automatic run_files(input int unsigned quota, input int unsigned lo_len,
                            input int unsigned hi_len, input bit close_last);
      int unsigned sent;
      int unsigned file_len;
      int unsigned k;
      bit          closing;
      bit          eof_on_record;
      req_type     it;
      sent = 0;
      while (sent < quota) begin
         file_len      = $urandom_range(lo_len, hi_len);
         sent         += file_len;
         closing       = close_last || sent < quota;
         eof_on_record = closing && ($urandom_range(0, 1) != 0);
         for (k = 0; k < file_len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               it              = random_record();
               it.record_valid = 1'b0;
               send_item(it, EXP_MODEL);
            end
            it             = random_record();
            it.end_of_file = eof_on_record && (k == file_len - 1);
            send_item(it, EXP_MODEL);
         end
         if (closing && !eof_on_record) begin
            it              = random_record();
            it.record_valid = 1'b0;
            it.end_of_file  = 1'b1;
            send_item(it, EXP_MODEL);
            sent++;
         end
      end
   endtask

   task automatic add_row(input logic rv, input logic eof, input logic [63:0] lo,
                          input logic [63:0] hi, input logic [31:0] ip,
                          input logic [15:0] udp, input logic [15:0] tcp,
                          input logic [7:0] ver, input check_kind_type kind);
      req_type it;
      it.record_valid = rv;
      it.end_of_file  = eof;
      it.peer_id_low  = lo;
      it.peer_id_high = hi;
      it.peer_ip      = ip;
      it.peer_udp     = udp;
      it.peer_tcp     = tcp;
      it.peer_version = ver;
      script_items.insert(script_items.size(), it);
      script_kinds.insert(script_kinds.size(), kind);
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_OWN_ID_LOW;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      foreach (id_pool[j]) id_pool[j] = {$urandom, $urandom, $urandom, $urandom};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at the reset configuration (own id 0, version floor 8, limit 50)
      // empty list at end of file
      add_row(1'b0, 1'b1, '0, '0, '0, '0, '0, '0, EXP_EMPTY);
      // no record: fields ignored
      add_row(1'b0, 1'b0, '1, '1, '1, '1, '1, '1, EXP_MODEL);
      // version just below the floor is dropped
      add_row(1'b1, 1'b1, 64'h5, 64'h0, 32'h0a000001, 16'd4672, 16'd4662, 8'd7, EXP_EMPTY);
      // record with end of file, all ones and all zeros
      add_row(1'b1, 1'b1, '1, '1, '1, '1, '1, 8'hff, EXP_SOLE);
      add_row(1'b1, 1'b1, '0, '0, '0, '0, '0, 8'd8, EXP_SOLE);
      add_row(1'b0, 1'b1, '1, '1, '1, '1, '1, '1, EXP_EMPTY);
      // build a list: equal distance goes after, high half dominates
      add_row(1'b1, 1'b0, 64'h5, 64'h0, 32'hc0a80001, 16'h1111, 16'h2222, 8'd8, EXP_MODEL);
      add_row(1'b1, 1'b0, 64'h5, 64'h0, 32'hc0a80002, 16'h3333, 16'h4444, 8'd9, EXP_MODEL);
      add_row(1'b1, 1'b0, 64'h0, 64'h1, 32'h7f000001, 16'h0001, 16'hfffe, 8'd10, EXP_MODEL);
      add_row(1'b1, 1'b0, '1, 64'h0, 32'h08080808, 16'hfffe, 16'h0001, 8'd11, EXP_MODEL);
      add_row(1'b1, 1'b0, 64'h0, 64'h0, 32'h01020304, 16'h0050, 16'h01bb, 8'd12, EXP_MODEL);
      add_row(1'b1, 1'b0, '1, '1, 32'hfffffffe, 16'hffff, 16'h0000, 8'd255, EXP_MODEL);
      add_row(1'b1, 1'b0, 64'h1, 64'h0, 32'h0, 16'h0, 16'h0, 8'd7, EXP_MODEL);
      add_row(1'b0, 1'b0, 64'h2, 64'h0, 32'h1, 16'h1, 16'h1, 8'd200, EXP_MODEL);
      add_row(1'b1, 1'b1, 64'h3, 64'h0, 32'haabbccdd, 16'h1234, 16'h5678, 8'd8, EXP_MODEL);
      add_row(1'b0, 1'b1, '0, '0, '0, '0, '0, '0, EXP_EMPTY);
      // top-bit and alternating bit patterns
      add_row(1'b1, 1'b0, 64'h0, 64'h8000000000000000, 32'h80000001, 16'h8001, 16'h7ffe,
              8'h80, EXP_MODEL);
      add_row(1'b1, 1'b1, 64'h8000000000000000, 64'h0, 32'h55555555, 16'haaaa, 16'h5555,
              8'haa, EXP_MODEL);
      foreach (script_items[i]) send_item(script_items[i], script_kinds[i]);

      // random own id, small limit so the list overflows
      settle();
      configure({$urandom, $urandom}, {$urandom, $urandom}, 8'd8, 7'd5);
      run_files(30, 1, 12, 1'b1);

      // full capacity
      settle();
      configure({$urandom, $urandom}, {$urandom, $urandom}, 8'd8, 7'd64);
      run_files(66, 66, 80, 1'b1);

      // limit 0 acts as 1, every version kept
      settle();
      configure({$urandom, $urandom}, {$urandom, $urandom}, 8'd0, 7'd0);
      run_files(25, 1, 6, 1'b1);

      // limit above capacity, only the top version kept
      settle();
      configure('1, '1, 8'd255, 7'd127);
      run_files(25, 1, 10, 1'b1);

      // leave a list held, then lower the limit and move the own id under it
      settle();
      configure({$urandom, $urandom}, {$urandom, $urandom}, 8'd8, 7'd20);
      run_files(20, 10, 20, 1'b0);
      settle();
      configure({$urandom, $urandom}, {$urandom, $urandom}, 8'd8, 7'd2);
      run_files(25, 1, 6, 1'b1);

      // reset-like limit, own id all ones
      settle();
      configure('1, '1, 8'd8, KEEP_LIMIT_RST);
      run_files(30, 1, 15, 1'b1);

      // single slot, own id zero
      settle();
      configure('0, '0, 8'd8, 7'd1);
      run_files(20, 1, 5, 1'b1);

      settle();
      configure({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom_range(0, 16)), 7'd10);
      run_files(30, 1, 14, 1'b1);

      settle();
      if (!failed) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### closest_peer_keeper_core.f
design/cpk_pkg.sv
design/cpk_ctrl.sv
design/cpk_datapath.sv
design/closest_peer_keeper_core.sv
verif/tb_closest_peer_keeper_core.sv
